[hw/rtl/assert_macros.svh]
// Assertion macros for the KMP stream matcher.
// Expects clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define KMS_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define KMS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

[hw/rtl/kms_pkg.sv]
// Shared types and constants for the KMP stream matcher.
// No dependencies.
`default_nettype none

package kms_pkg;

	localparam int POS_W  = 32;
	localparam int BYTE_W = 8;
	localparam int ACT_W  = 2;

	typedef enum logic [ACT_W-1:0] {
		ACT_CLEAR   = 2'd0,
		ACT_APPEND  = 2'd1,
		ACT_TEXT    = 2'd2,
		ACT_RESTART = 2'd3
	} action_t;

	typedef enum logic {
		STAT_MATCH = 1'b0,
		STAT_FULL  = 1'b1
	} status_t;

	typedef struct packed {
		status_t          status;
		logic [POS_W-1:0] match_start;
	} result_t;

endpackage

`default_nettype wire

[hw/rtl/kmp_stream_matcher.sv]
// Top level of the KMP stream matcher: sequencer, failure-chain walk, output register.
// Depends on kms_pkg, kms_ram and assert_macros.svh.
//
// channel   dir  tdata                    tuser
// s_*       in   [7:0] data_byte          [1:0] action
// m_*       out  [31:0] match_start       [0] status
//
// Clear, restart, a first append and text bytes on an empty pattern finish in ST_IDLE.
// Other appends below capacity and text bytes walk the failure chain in ST_WALK; each step is one
// read of the pattern RAM and prefix RAM, and the input is not ready until the walk ends.
// A result (match or refused append) passes through ST_EMIT to load the output register; a
// result that finds that register still full waits there and holds off the input.
// arst_n clears control state; RAM contents are only used below the pattern length.
`default_nettype none

module kmp_stream_matcher #(
	parameter int PATTERN_MAX = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic [1:0]  s_tuser,   // [1:0] action
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [31:0] match_start
	output logic [0:0]       m_tuser    // [0] status
);

	localparam int IW = $clog2(PATTERN_MAX);
	localparam int LW = $clog2(PATTERN_MAX + 1);
	localparam logic [LW-1:0] LEN_MAX = LW'(PATTERN_MAX);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t                      state_q;
	logic [LW-1:0]               len_q;
	logic [IW-1:0]               build_q;
	logic [IW-1:0]               midx_q;
	logic [kms_pkg::POS_W-1:0]   tpos_q;
	logic                        out_valid_q;
	kms_pkg::result_t            out_q;
	kms_pkg::result_t            res_q;
	logic [IW-1:0]               k_q;
	logic [kms_pkg::BYTE_W-1:0]  b_q;
	logic                        is_text_q;
	logic [IW-1:0]               last_tab_q;

	kms_pkg::action_t            act;
	logic                        acc;
	logic                        full;
	logic [IW-1:0]               init_k;
	logic [IW-1:0]               nk;
	logic [IW-1:0]               rd_k;
	logic                        step_fail;
	logic [LW-1:0]               k_done;
	logic                        emit_ok;
	logic                        idle_nonempty;

	logic                        pat_we;
	logic                        tab_we;
	logic [kms_pkg::BYTE_W-1:0]  pat_wdata;
	logic [IW-1:0]               tab_wdata;
	logic [kms_pkg::BYTE_W-1:0]  pat_rdata;
	logic [IW-1:0]               tab_rdata;

	assign act      = kms_pkg::action_t'(s_tuser);
	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign full     = (len_q >= LEN_MAX);
	assign emit_ok  = !out_valid_q || m_tready;
	assign idle_nonempty = (state_q == ST_IDLE) && (len_q != '0);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.match_start;
	assign m_tuser  = out_q.status;

	// Starting state of the walk; a stale index past the pattern restarts at zero.
	always_comb begin
		init_k = '0;
		if (act == kms_pkg::ACT_APPEND) begin
			if ({1'b0, build_q} < len_q) begin
				init_k = build_q;
			end
		end else begin
			if ({1'b0, midx_q} < len_q) begin
				init_k = midx_q;
			end
		end
	end

	assign step_fail = (k_q != '0) && (pat_rdata != b_q);
	assign nk        = (tab_rdata < k_q) ? tab_rdata : '0;
	assign k_done    = {1'b0, k_q} + LW'(pat_rdata == b_q);
	// Next read address: start of walk when idle, failure link while walking.
	assign rd_k      = (state_q == ST_IDLE) ? init_k : nk;

	// Both RAMs are written together on an append; the written entry is at the
	// pattern length, never read by the walk that wrote it.
	always_comb begin
		pat_we    = 1'b0;
		pat_wdata = b_q;
		tab_wdata = k_done[IW-1:0];
		if (state_q == ST_IDLE) begin
			pat_we    = acc && (act == kms_pkg::ACT_APPEND) && (len_q == '0);
			pat_wdata = s_tdata;
			tab_wdata = '0;
		end else if (state_q == ST_WALK) begin
			pat_we = !is_text_q && !step_fail;
		end
	end
	assign tab_we = pat_we;

	kms_ram #(.DEPTH(PATTERN_MAX), .WIDTH(kms_pkg::BYTE_W)) u_pat_ram (
		.clk   (clk),
		.we    (pat_we),
		.waddr (len_q[IW-1:0]),
		.wdata (pat_wdata),
		.raddr (rd_k),
		.rdata (pat_rdata)
	);

	kms_ram #(.DEPTH(PATTERN_MAX), .WIDTH(IW)) u_tab_ram (
		.clk   (clk),
		.we    (tab_we),
		.waddr (len_q[IW-1:0]),
		.wdata (tab_wdata),
		.raddr (rd_k - IW'(1)),
		.rdata (tab_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			build_q     <= '0;
			midx_q      <= '0;
			tpos_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && emit_ok) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						unique case (act)
							kms_pkg::ACT_CLEAR: begin
								len_q   <= '0;
								build_q <= '0;
								midx_q  <= '0;
							end
							kms_pkg::ACT_APPEND: begin
								if (full) begin
									state_q <= ST_EMIT;
								end else if (len_q == '0) begin
									build_q <= '0;
									len_q   <= LW'(1);
									midx_q  <= '0;
								end else begin
									state_q <= ST_WALK;
								end
							end
							kms_pkg::ACT_TEXT: begin
								tpos_q <= tpos_q + kms_pkg::POS_W'(1);
								if (len_q != '0) begin
									state_q <= ST_WALK;
								end
							end
							kms_pkg::ACT_RESTART: begin
								tpos_q <= '0;
								midx_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_WALK: begin
					if (!step_fail) begin
						if (!is_text_q) begin
							build_q <= k_done[IW-1:0];
							len_q   <= len_q + LW'(1);
							midx_q  <= '0;
							state_q <= ST_IDLE;
						end else if (k_done == len_q) begin
							midx_q  <= last_tab_q;
							state_q <= ST_EMIT;
						end else begin
							midx_q  <= k_done[IW-1:0];
							state_q <= ST_IDLE;
						end
					end
				end
				ST_EMIT: begin
					if (emit_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && acc) begin
			k_q       <= init_k;
			b_q       <= s_tdata;
			is_text_q <= (act == kms_pkg::ACT_TEXT);
			res_q     <= '{status: kms_pkg::STAT_FULL, match_start: '0};
		end else if (state_q == ST_WALK) begin
			k_q   <= nk;
			res_q <= '{status: kms_pkg::STAT_MATCH,
			           match_start: tpos_q - kms_pkg::POS_W'(len_q)};
		end
		if (tab_we) begin
			last_tab_q <= tab_wdata;
		end
		if (state_q == ST_EMIT && emit_ok) begin
			out_q <= res_q;
		end
	end

`include "assert_macros.svh"

	`KMS_ASSERT_ALWAYS(a_len_bound, len_q <= LEN_MAX, "pattern length above capacity")
	`KMS_ASSERT_IMPL(a_walk_idx, state_q == ST_WALK, {1'b0, k_q} < len_q, "walk index past pattern")
	`KMS_ASSERT_IMPL(a_midx_bound, idle_nonempty, {1'b0, midx_q} < len_q, "match index past pattern")
	`KMS_ASSERT_IMPL(a_build_bound, idle_nonempty, {1'b0, build_q} < len_q, "border past pattern")

endmodule

`default_nettype wire

[hw/rtl/kms_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on nothing.
`default_nettype none

module kms_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[test/tb_top.sv]
// Self-checking bench for kmp_stream_matcher: directed rows, then random pattern/text runs.
// Transactions are scored against an in-bench KMP search predictor; depends on kms_pkg.
`timescale 1ns / 100ps

module tb_top;

	localparam int PAT_MAX     = 64;
	localparam int RAND_ITEMS  = 550;
	localparam int HOLD_CYCLES = 300;
	localparam int WD_LIMIT    = 3000;
	localparam int DRAIN_WAIT  = 150;
	localparam int MAX_PRINTS  = 40;

	typedef enum int {
		CHK_MODEL,   // expectation from the predictor
		CHK_QUIET,   // typed: no result
		CHK_TYPED    // typed: one result as given in the row
	} check_kind_t;

	typedef struct {
		kms_pkg::action_t act;
		logic [7:0]       data;
		int               reps;
		check_kind_t      chk;
		kms_pkg::status_t stat;
		logic [31:0]      start;
	} stim_row_t;

	typedef struct {
		kms_pkg::action_t act;
		logic [7:0]       data;
	} stim_item_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [0:0]  m_tuser;

	// predictor state
	logic [7:0]  pat_mem [PAT_MAX];
	int          border_mem [PAT_MAX];
	int          pat_len;
	int          build_k;
	int          match_k;
	logic [31:0] text_pos;

	kms_pkg::result_t pending_reports [$];
	stim_item_t       queued_items [$];
	stim_row_t        dir_tab [$];
	kms_pkg::result_t got_exp;

	int err_cnt = 0;
	int idle_cyc = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;
	bit hold_req = 1'b0;

	kmp_stream_matcher #(.PATTERN_MAX(PAT_MAX)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (err_cnt < MAX_PRINTS)
			$display("%0t ERROR %s: got %0h, expected %0h", $realtime, what, got, want);
		err_cnt++;
	endtask

	task automatic queue_item(input stim_item_t it);
		queued_items.insert(queued_items.size(), it);
	endtask

	task automatic queue_row(input stim_row_t row);
		dir_tab.insert(dir_tab.size(), row);
	endtask

	task automatic queue_report(input kms_pkg::result_t r);
		pending_reports.insert(pending_reports.size(), r);
	endtask

	function automatic logic [7:0] pat_byte(input int i);
		return (i < PAT_MAX) ? pat_mem[i] : 8'h00;
	endfunction

	function automatic int border_of(input int i);
		return (i >= 0 && i < PAT_MAX) ? border_mem[i] : 0;
	endfunction

	// failure-chain walk from state k on byte b
	function automatic int chain_walk(input int k, input logic [7:0] b);
		int nk;
		while (k > 0 && pat_byte(k) != b) begin
			nk = border_of(k - 1);
			k = (nk < k) ? nk : 0;
		end
		if (pat_byte(k) == b)
			k++;
		return k;
	endfunction

	task automatic search_reset();
		for (int i = 0; i < PAT_MAX; i++) begin
			pat_mem[i] = 8'h00;
			border_mem[i] = 0;
		end
		pat_len = 0;
		build_k = 0;
		match_k = 0;
		text_pos = '0;
	endtask

	task automatic search_step(input kms_pkg::action_t act, input logic [7:0] b,
			output bit hit, output kms_pkg::result_t res);
		int j;
		hit = 1'b0;
		res = '0;
		case (act)
			kms_pkg::ACT_CLEAR: begin
				pat_len = 0;
				build_k = 0;
				match_k = 0;
			end
			kms_pkg::ACT_APPEND: begin
				if (pat_len >= PAT_MAX) begin
					hit = 1'b1;
					res.status = kms_pkg::STAT_FULL;
					res.match_start = '0;
				end else begin
					pat_mem[pat_len] = b;
					if (pat_len == 0) begin
						build_k = 0;
					end else begin
						j = (build_k >= pat_len) ? 0 : build_k;
						build_k = chain_walk(j, b);
					end
					border_mem[pat_len] = build_k;
					pat_len++;
					match_k = 0;
				end
			end
			kms_pkg::ACT_RESTART: begin
				text_pos = '0;
				match_k = 0;
			end
			default: begin
				text_pos = text_pos + 32'd1;
				if (pat_len != 0) begin
					j = (match_k >= pat_len) ? 0 : match_k;
					j = chain_walk(j, b);
					if (j >= pat_len) begin
						hit = 1'b1;
						res.status = kms_pkg::STAT_MATCH;
						res.match_start = text_pos - 32'(pat_len);
						match_k = border_of(pat_len - 1);
					end else begin
						match_k = j;
					end
				end
			end
		endcase
	endtask

	// offer one transaction, wait for it, then score it
	task automatic send_item(input kms_pkg::action_t act, input logic [7:0] dv,
			input check_kind_t chk, input kms_pkg::result_t typed);
		bit               hit;
		kms_pkg::result_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= dv;
		do
			@(posedge clk);
		while (!s_tready);
		search_step(act, dv, hit, res);
		if (chk == CHK_MODEL && hit)
			queue_report(res);
		else if (chk == CHK_TYPED)
			queue_report(typed);
	endtask

	// one random run: mostly a pattern build followed by text over a small alphabet
	task automatic gen_sequence();
		logic [7:0] syms [3];
		logic [7:0] seq_pat [PAT_MAX];
		int nsym, plen, tlen, n;
		if ($urandom_range(99) < 12) begin
			n = $urandom_range(1, 8);
			for (int i = 0; i < n; i++)
				queue_item('{kms_pkg::action_t'($urandom_range(3)),
					8'($urandom_range(255))});
			return;
		end
		nsym = $urandom_range(1, 3);
		for (int i = 0; i < 3; i++)
			syms[i] = 8'($urandom_range(255));
		plen = ($urandom_range(19) == 0) ? $urandom_range(60, 67) : $urandom_range(1, 6);
		// sometimes extend whatever pattern is there
		if ($urandom_range(3) != 0)
			queue_item('{kms_pkg::ACT_CLEAR, 8'($urandom_range(255))});
		for (int i = 0; i < plen; i++) begin
			n = $urandom_range(nsym - 1);
			if (i < PAT_MAX)
				seq_pat[i] = syms[n];
			queue_item('{kms_pkg::ACT_APPEND, syms[n]});
		end
		if ($urandom_range(3) == 0)
			queue_item('{kms_pkg::ACT_RESTART, 8'($urandom_range(255))});
		tlen = $urandom_range(10, 40);
		for (int i = 0; i < tlen; i++) begin
			n = $urandom_range(5);
			if (n == 0) begin
				for (int k = 0; k < plen && k < PAT_MAX; k++)
					queue_item('{kms_pkg::ACT_TEXT, seq_pat[k]});
			end else if (n == 1) begin
				queue_item('{kms_pkg::ACT_TEXT, 8'($urandom_range(255))});
			end else begin
				queue_item('{kms_pkg::ACT_TEXT, syms[$urandom_range(nsym - 1)]});
			end
		end
	endtask

	// output scoreboard
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reports.size() == 0) begin
				report_mismatch("result with nothing pending", m_tdata, 32'h0);
			end else begin
				got_exp = pending_reports.pop_front();
				if (m_tdata !== got_exp.match_start)
					report_mismatch("match_start", m_tdata, got_exp.match_start);
				if (m_tuser[0] !== got_exp.status)
					report_mismatch("status", 32'(m_tuser), 32'(got_exp.status));
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cyc <= 0;
			else
				idle_cyc <= idle_cyc + 1;
			if (idle_cyc >= WD_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// receiver: random backpressure plus one long hold-off on request
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		stim_item_t       it;
		kms_pkg::result_t no_res;
		kms_pkg::result_t typed;
		int               rand_sent;
		int               phase;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'h00;
		s_tuser  = kms_pkg::ACT_CLEAR;
		no_res   = '0;
		rand_sent = 0;
		phase = 0;
		search_reset();

		// empty pattern after reset
		queue_row('{kms_pkg::ACT_TEXT,    8'h00, 1,  CHK_QUIET, kms_pkg::STAT_MATCH, 32'd0});
		queue_row('{kms_pkg::ACT_APPEND,  8'h61, 1,  CHK_QUIET, kms_pkg::STAT_MATCH, 32'd0});
		queue_row('{kms_pkg::ACT_APPEND,  8'h62, 1,  CHK_QUIET, kms_pkg::STAT_MATCH, 32'd0});
		queue_row('{kms_pkg::ACT_APPEND,  8'h61, 1,  CHK_QUIET, kms_pkg::STAT_MATCH, 32'd0});
		// overlapping matches of "aba" in "ababa"
		queue_row('{kms_pkg::ACT_TEXT,    8'h61, 1,  CHK_MODEL, kms_pkg::STAT_MATCH, 32'd0});
		queue_row('{kms_pkg::ACT_TEXT,    8'h62, 1,  CHK_MODEL, kms_pkg::STAT_MATCH, 32'd0});
		queue_row('{kms_pkg::ACT_TEXT,    8'h61, 1,  CHK_MODEL, kms_pkg::STAT_MATCH, 32'd0});
		queue_row('{kms_pkg::ACT_TEXT,    8'h62, 1,  CHK_MODEL, kms_pkg::STAT_MATCH, 32'd0});
		queue_row('{kms_pkg::ACT_TEXT,    8'h61, 1,  CHK_MODEL, kms_pkg::STAT_MATCH, 32'd0});
		// restart: match starts at position zero
		queue_row('{kms_pkg::ACT_RESTART, 8'hff, 1,  CHK_QUIET, kms_pkg::STAT_MATCH, 32'd0});
		queue_row('{kms_pkg::ACT_TEXT,    8'h61, 1,  CHK_QUIET, kms_pkg::STAT_MATCH, 32'd0});
		queue_row('{kms_pkg::ACT_TEXT,    8'h62, 1,  CHK_QUIET, kms_pkg::STAT_MATCH, 32'd0});
		queue_row('{kms_pkg::ACT_TEXT,    8'h61, 1,  CHK_TYPED, kms_pkg::STAT_MATCH, 32'd0});
		queue_row('{kms_pkg::ACT_CLEAR,   8'h55, 1,  CHK_QUIET, kms_pkg::STAT_MATCH, 32'd0});
		queue_row('{kms_pkg::ACT_TEXT,    8'hff, 1,  CHK_QUIET, kms_pkg::STAT_MATCH, 32'd0});
		// byte extremes
		queue_row('{kms_pkg::ACT_APPEND,  8'h00, 1,  CHK_QUIET, kms_pkg::STAT_MATCH, 32'd0});
		queue_row('{kms_pkg::ACT_APPEND,  8'hff, 1,  CHK_QUIET, kms_pkg::STAT_MATCH, 32'd0});
		queue_row('{kms_pkg::ACT_TEXT,    8'h00, 1,  CHK_MODEL, kms_pkg::STAT_MATCH, 32'd0});
		queue_row('{kms_pkg::ACT_TEXT,    8'hff, 1,  CHK_MODEL, kms_pkg::STAT_MATCH, 32'd0});
		// full pattern, refused appends, back-to-back overlapping matches
		queue_row('{kms_pkg::ACT_CLEAR,   8'h00, 1,  CHK_QUIET, kms_pkg::STAT_MATCH, 32'd0});
		queue_row('{kms_pkg::ACT_RESTART, 8'h00, 1,  CHK_QUIET, kms_pkg::STAT_MATCH, 32'd0});
		queue_row('{kms_pkg::ACT_APPEND,  8'h5a, 64, CHK_QUIET, kms_pkg::STAT_MATCH, 32'd0});
		queue_row('{kms_pkg::ACT_APPEND,  8'ha5, 1,  CHK_TYPED, kms_pkg::STAT_FULL,  32'd0});
		queue_row('{kms_pkg::ACT_TEXT,    8'h5a, 66, CHK_MODEL, kms_pkg::STAT_MATCH, 32'd0});
		queue_row('{kms_pkg::ACT_APPEND,  8'h00, 1,  CHK_TYPED, kms_pkg::STAT_FULL,  32'd0});
		queue_row('{kms_pkg::ACT_TEXT,    8'h5a, 2,  CHK_MODEL, kms_pkg::STAT_MATCH, 32'd0});
		queue_row('{kms_pkg::ACT_CLEAR,   8'hff, 1,  CHK_QUIET, kms_pkg::STAT_MATCH, 32'd0});

		send_idle_pct = 38;
		recv_idle_pct = 86;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[r]) begin
			typed = '0;
			typed.status = dir_tab[r].stat;
			typed.match_start = dir_tab[r].start;
			for (int n = 0; n < dir_tab[r].reps; n++)
				send_item(dir_tab[r].act, dir_tab[r].data, dir_tab[r].chk, typed);
		end

		while (rand_sent < RAND_ITEMS) begin
			if (rand_sent * 3 >= 2 * RAND_ITEMS && phase != 2) begin
				phase = 2;
				send_idle_pct = 0;
				recv_idle_pct = 0;
				hold_req = 1'b1;   // fill the block while the sender keeps offering
			end else if (rand_sent * 3 >= RAND_ITEMS && phase == 0) begin
				phase = 1;
				send_idle_pct = 86;
				recv_idle_pct = 38;
			end
			if (queued_items.size() == 0)
				gen_sequence();
			it = queued_items.pop_front();
			send_item(it.act, it.data, CHK_MODEL, no_res);
			rand_sent++;
		end
		s_tvalid <= 1'b0;

		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (pending_reports.size() != 0)
			report_mismatch("results never delivered", 32'(pending_reports.size()), 32'd0);

		if (err_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
